FILE: rtl/ppd_pkg.sv
package ppd_pkg;

  // sample and coefficient formats
  localparam int SMP_W     = 24;
  localparam int FRAC_W    = 16;
  localparam int COEF_W    = 17;
  localparam int ALPHA_W   = 16;
  localparam int DELAY_W   = 17;
  localparam int MUL_W     = COEF_W + 1;
  localparam int PROD_W    = MUL_W + SMP_W;
  localparam int ACC_W     = PROD_W + 1;

  // delay line, power of two deep
  localparam int BUF_LEN   = 131072;
  localparam int ADDR_W    = $clog2(BUF_LEN);

  // stream and register port widths
  localparam int TDATA_W    = ((2 * SMP_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [COEF_W-1:0]  UNITY      = COEF_W'(1 << FRAC_W);
  localparam logic [DELAY_W-1:0] DELAY_RST  = DELAY_W'(24000);
  localparam logic [ACC_W-1:0]   RND_HALF   = ACC_W'(1 << (FRAC_W - 1));

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic [COEF_W-1:0]       coef_t;

  localparam sample_t SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = CFG_IDX_W'(0),
    REG_FEEDBACK = CFG_IDX_W'(1),
    REG_MIX      = CFG_IDX_W'(2),
    REG_ALPHA    = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_DONE
  } state_t;

  // multiply steps of the shared unit, in issue order
  typedef enum logic [3:0] {
    MS_LPL_A,
    MS_LPL_X,
    MS_LPR_A,
    MS_LPR_X,
    MS_FBL_X,
    MS_FBL_Y,
    MS_FBR_X,
    MS_FBR_Y,
    MS_OUTL_X,
    MS_OUTL_Y,
    MS_OUTR_X,
    MS_OUTR_Y,
    MS_DRAIN
  } mac_step_t;

endpackage

FILE: rtl/ping_pong_delay_lowpass_feedback.sv
// Stereo ping-pong delay with a one-pole low-pass in the echo path. Each input
// transaction carries one Q1.23 stereo pair; each echo is read delay_samples back,
// filtered (y = a*y + (1-a)*x), fed crosswise into the other channel's delay
// line scaled by feedback_gain, and mixed with the dry input by wet_mix. All
// sums round half up and saturate to 24 bits. One 18x24 multiplier with an
// accumulator does all twelve products in turn, so a processed pair holds the
// block through accept, one delay line read, 12 multiply issues plus a drain
// step, and output load; the input is not ready during that time. With
// wet_mix at zero the pair skips the read and the multiply steps, goes from
// acceptance straight to the output load, and no state moves. A result held by
// the receiver stalls the block in its output load cycle. The two delay lines
// share one 48-bit memory with a registered read. There is no
// clearing pass: the delay line is filled strictly in write-pointer order, so a
// location not yet written (before the pointer first wraps) is read as silence.
// Registers take a write in any cycle, but should only be changed while the block
// is idle.
module ping_pong_delay_lowpass_feedback (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream: [23:0] left_in, [47:24] right_in
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ppd_pkg::TDATA_W-1:0]    in_tdata,
  // result stream: [23:0] left_out, [47:24] right_out
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ppd_pkg::TDATA_W-1:0]    out_tdata,
  // register write port
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppd_pkg::*;

  // configuration registers
  logic [DELAY_W-1:0] delay_r;
  coef_t              fb_gain_r;
  coef_t              wet_mix_r;
  logic [ALPHA_W-1:0] alpha_r;

  // sequencer
  state_t    state_r, state_nxt;
  mac_step_t step_r, step_nxt;
  mac_step_t prod_step_r;
  logic      prod_vld_r, prod_vld_nxt;
  logic      byp_r;

  // delay line bookkeeping
  logic [ADDR_W-1:0] wp_r;
  logic              wrapped_r;
  logic [ADDR_W-1:0] d_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_ok;
  logic              rd_ok_r;
  logic [2*SMP_W-1:0] mem [BUF_LEN];
  logic [2*SMP_W-1:0] mem_q;

  // datapath
  sample_t x_l_r, x_r_r;
  sample_t lp_l_r, lp_r_r;
  sample_t wl_r;
  sample_t res_l_r, res_r_r;
  sample_t echo_l, echo_r;
  sample_t smp_op;
  coef_t   coef_val;
  logic signed [MUL_W-1:0]  coef_op;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_sum;
  sample_t fin;

  coef_t mix_c, fb_c, alpha_c, ialpha, imix;

  // handshake controls
  logic in_fire;
  logic out_load;
  logic mem_re;
  logic mem_we;

  // round-half-up by 2^16 already folded into the sum; drop fraction and clamp
  function automatic sample_t sat_shift(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-FRAC_W-1:0] sh;
    logic                    fits;
    sh   = v[ACC_W-1:FRAC_W];
    fits = (&sh[ACC_W-FRAC_W-1:SMP_W-1]) || !(|sh[ACC_W-FRAC_W-1:SMP_W-1]);
    if (fits) begin
      return sample_t'(sh[SMP_W-1:0]);
    end else if (sh[ACC_W-FRAC_W-1]) begin
      return SMP_MIN;
    end else begin
      return SMP_MAX;
    end
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r   <= DELAY_RST;
      fb_gain_r <= '0;
      wet_mix_r <= '0;
      alpha_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DELAY:    delay_r   <= cfg_data[DELAY_W-1:0];
        REG_FEEDBACK: fb_gain_r <= cfg_data[COEF_W-1:0];
        REG_MIX:      wet_mix_r <= cfg_data[COEF_W-1:0];
        REG_ALPHA:    alpha_r   <= cfg_data[ALPHA_W-1:0];
        default: ;  // unknown register: write dropped
      endcase
    end
  end

  // gains above unity clamp to unity; complements for the (1-a) and (1-m) terms
  always_comb begin
    mix_c   = (wet_mix_r > UNITY) ? UNITY : wet_mix_r;
    fb_c    = (fb_gain_r > UNITY) ? UNITY : fb_gain_r;
    alpha_c = COEF_W'(alpha_r);
    ialpha  = UNITY - alpha_c;
    imix    = UNITY - mix_c;
  end

  // delay distance clamped to 1 .. BUF_LEN-1; read address wraps modulo BUF_LEN
  always_comb begin
    if (delay_r == '0) begin
      d_addr = ADDR_W'(1);
    end else if (32'(delay_r) > 32'(BUF_LEN - 1)) begin
      d_addr = ADDR_W'(BUF_LEN - 1);
    end else begin
      d_addr = ADDR_W'(delay_r);
    end
    rd_addr = wp_r - d_addr;
    // before the first wrap only locations below the write pointer hold data
    rd_ok   = wrapped_r || (wp_r >= d_addr);
  end

  assign in_fire = in_tvalid && in_tready;

  // next state and control outputs
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    prod_vld_nxt = 1'b0;
    in_tready    = 1'b0;
    mem_re       = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (wet_mix_r == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        step_nxt  = MS_LPL_A;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (step_r == MS_DRAIN) begin
          state_nxt = ST_DONE;
        end else begin
          prod_vld_nxt = 1'b1;
          step_nxt     = mac_step_t'(step_r + 1'b1);
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_tvalid || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= MS_LPL_A;
      prod_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      prod_vld_r <= prod_vld_nxt;
    end
  end

  // capture input pair; bypass result is the input itself
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_l_r <= sample_t'(in_tdata[SMP_W-1:0]);
      x_r_r <= sample_t'(in_tdata[2*SMP_W-1:SMP_W]);
      byp_r <= (wet_mix_r == '0);
    end
  end

  // delay line memory, both channels side by side
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= {fin, wl_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q   <= mem[rd_addr];
      rd_ok_r <= rd_ok;
    end
  end

  assign echo_l = rd_ok_r ? sample_t'(mem_q[SMP_W-1:0])       : '0;
  assign echo_r = rd_ok_r ? sample_t'(mem_q[2*SMP_W-1:SMP_W]) : '0;

  // operand select for the shared multiplier
  always_comb begin
    coef_val = '0;
    smp_op   = '0;
    case (step_r)
      MS_LPL_A:  begin coef_val = alpha_c; smp_op = lp_l_r; end
      MS_LPL_X:  begin coef_val = ialpha;  smp_op = echo_l; end
      MS_LPR_A:  begin coef_val = alpha_c; smp_op = lp_r_r; end
      MS_LPR_X:  begin coef_val = ialpha;  smp_op = echo_r; end
      // unity times the dry sample puts it at the product's binary point
      MS_FBL_X:  begin coef_val = UNITY;   smp_op = x_l_r;  end
      MS_FBL_Y:  begin coef_val = fb_c;    smp_op = lp_r_r; end
      MS_FBR_X:  begin coef_val = UNITY;   smp_op = x_r_r;  end
      MS_FBR_Y:  begin coef_val = fb_c;    smp_op = lp_l_r; end
      MS_OUTL_X: begin coef_val = imix;    smp_op = x_l_r;  end
      MS_OUTL_Y: begin coef_val = mix_c;   smp_op = lp_l_r; end
      MS_OUTR_X: begin coef_val = imix;    smp_op = x_r_r;  end
      MS_OUTR_Y: begin coef_val = mix_c;   smp_op = lp_r_r; end
      default: ;
    endcase
    coef_op = $signed({1'b0, coef_val});
  end

  // product register, then accumulate in the following cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_MAC) begin
      prod_r      <= coef_op * smp_op;
      prod_step_r <= step_r;
    end
  end

  assign acc_sum = acc_r + ACC_W'(prod_r);
  assign fin     = sat_shift(acc_sum);
  assign mem_we  = prod_vld_r && (prod_step_r == MS_FBR_Y);

  // first product of a pair opens the sum with the rounding half,
  // second product closes it into its destination
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_l_r <= '0;
      lp_r_r <= '0;
    end else if (prod_vld_r) begin
      case (prod_step_r)
        MS_LPL_A, MS_LPR_A, MS_FBL_X, MS_FBR_X, MS_OUTL_X, MS_OUTR_X:
          acc_r <= ACC_W'(prod_r) + RND_HALF;
        MS_LPL_X:  lp_l_r  <= fin;
        MS_LPR_X:  lp_r_r  <= fin;
        MS_FBL_Y:  wl_r    <= fin;
        MS_OUTL_Y: res_l_r <= fin;
        MS_OUTR_Y: res_r_r <= fin;
        default: ;  // right feedback sum goes straight into the memory
      endcase
    end else if (in_fire && (wet_mix_r == '0)) begin
      res_l_r <= sample_t'(in_tdata[SMP_W-1:0]);
      res_r_r <= sample_t'(in_tdata[2*SMP_W-1:SMP_W]);
    end
  end

  // write pointer moves once per processed pair, never on bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (out_load && !byp_r) begin
      wp_r <= wp_r + 1'b1;
      if (wp_r == ADDR_W'(BUF_LEN - 1)) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata <= TDATA_W'({res_r_r, res_l_r});
    end
  end

`ifndef NO_ASSERTIONS
  // a pass-through transaction skips the delay line and echoes the input
  a_bypass_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (wet_mix_r == '0)) |=>
      (state_r == ST_DONE) && ({res_r_r, res_l_r} == $past(in_tdata[2*SMP_W-1:0])))
    else $error("bypass transaction did not pass its input through");

  // write pointer only moves when a processed result is handed to the output
  a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (wp_r != $past(wp_r))) |->
      ($past(state_r) == ST_DONE) && !$past(byp_r))
    else $error("write pointer moved outside a processed result");

  // filter state is frozen while idle with no transaction arriving
  a_lp_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && !in_tvalid) |=> $stable(lp_l_r) && $stable(lp_r_r))
    else $error("low-pass state changed while idle");

  // the delay line is only written during the multiply sequence
  a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_MAC) && !byp_r)
    else $error("delay line written outside the multiply sequence");
`endif

endmodule

FILE: tb/ping_pong_delay_lowpass_feedback_tb.sv
`timescale 1ns / 1ps

module ping_pong_delay_lowpass_feedback_tb;
  import ppd_pkg::*;

  // receiver hold-off used to fill the block and stall its input
  localparam int HOLD_CYCLES = 200;
  // register indexes past the end of the map, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_DELAY;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // idle rates in percent per cycle for each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // hold-off handshake between the test sequence and the receiver process
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  int mismatch_count = 0;

  // shadow of the block: registers, delay lines, pointer, filter states
  logic [DELAY_W-1:0]       delay_reg = DELAY_RST;
  coef_t                    fb_reg    = '0;
  coef_t                    mix_reg   = '0;
  logic [ALPHA_W-1:0]       alpha_reg = '0;
  bit signed [SMP_W-1:0]    echo_left  [BUF_LEN];
  bit signed [SMP_W-1:0]    echo_right [BUF_LEN];
  logic [ADDR_W-1:0]        wr_ptr   = '0;
  bit signed [SMP_W-1:0]    lp_left  = '0;
  bit signed [SMP_W-1:0]    lp_right = '0;

  // mixed pairs still owed by the block, oldest first
  stereo_t expected_pairs[$];

  ping_pong_delay_lowpass_feedback i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // fixed-point helpers: round half up to q0 from q16, then clip to 24 bits
  // ---------------------------------------------------------------------------
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clip_sample(input longint v);
    if (v > longint'(SMP_MAX)) return longint'(SMP_MAX);
    if (v < longint'(SMP_MIN)) return longint'(SMP_MIN);
    return v;
  endfunction

  // y' = a*y + (1-a)*x in q0.16
  function automatic longint one_pole(input longint a, input longint y, input longint x);
    return clip_sample(round_q16(a * y + (64'sd65536 - a) * x));
  endfunction

  // register write as the block sees it, extra data bits dropped
  task automatic shadow_config(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DELAY:    delay_reg = val[DELAY_W-1:0];
      REG_FEEDBACK: fb_reg    = val[COEF_W-1:0];
      REG_MIX:      mix_reg   = val[COEF_W-1:0];
      REG_ALPHA:    alpha_reg = val[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  // one stereo pair through the echo path, result queued for the checker
  task automatic predict_pair(input sample_t xl, input sample_t xr);
    longint             m, fb, a, yl, yr, dry_l, dry_r;
    logic [DELAY_W-1:0] dly;
    logic [ADDR_W-1:0]  rd;
    stereo_t            res;
    // zero mix: straight through, nothing in the state moves
    if (mix_reg == '0) begin
      res.left  = xl;
      res.right = xr;
      expected_pairs.push_back(res);
      return;
    end
    // gains above unity saturate, distance clamps into the delay line
    m  = (mix_reg > UNITY) ? longint'(UNITY) : longint'(mix_reg);
    fb = (fb_reg > UNITY) ? longint'(UNITY) : longint'(fb_reg);
    a  = longint'(alpha_reg);
    dly = delay_reg;
    if (dly == '0) dly = DELAY_W'(1);
    if (dly > DELAY_W'(BUF_LEN - 1)) dly = DELAY_W'(BUF_LEN - 1);
    rd = wr_ptr - ADDR_W'(dly);
    dry_l = longint'(xl);
    dry_r = longint'(xr);
    // read and filter both echoes first
    yl = one_pole(a, longint'(lp_left), longint'(echo_left[rd]));
    yr = one_pole(a, longint'(lp_right), longint'(echo_right[rd]));
    lp_left  = sample_t'(yl);
    lp_right = sample_t'(yr);
    // crosswise feedback into the delay lines
    echo_left[wr_ptr]  = sample_t'(clip_sample(dry_l + round_q16(fb * yr)));
    echo_right[wr_ptr] = sample_t'(clip_sample(dry_r + round_q16(fb * yl)));
    // dry / wet mix
    res.left  = sample_t'(clip_sample(round_q16(dry_l * (64'sd65536 - m) + yl * m)));
    res.right = sample_t'(clip_sample(round_q16(dry_r * (64'sd65536 - m) + yr * m)));
    wr_ptr = wr_ptr + 1'b1;
    expected_pairs.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // offer one pair after a random gap; valid stays up for the next call
  task automatic send_pair(input sample_t xl, input sample_t xr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {xr, xl};
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_pair(xl, xr);
  endtask

  // stop offering and wait until every owed result has been taken
  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // register write transaction, only issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    shadow_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // full-range noise half the time, with rails, silence and near-zero values mixed in
  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3: return sample_t'(int'($urandom_range(512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // new setting for all four registers, extremes weighted in
  task automatic configure_random();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = CFG_DATA_W'(BUF_LEN - 1);
      2: v = CFG_DATA_W'(DELAY_RST);
      default: v = CFG_DATA_W'($urandom_range(48, 1));
    endcase
    write_reg(REG_DELAY, v);
    case ($urandom_range(5))
      0: v = '0;
      1: v = UNITY;
      2: v = CFG_DATA_W'($urandom_range(131071, 65537));
      default: v = CFG_DATA_W'($urandom_range(65536));
    endcase
    write_reg(REG_FEEDBACK, v);
    case ($urandom_range(9))
      0: v = '0;
      1: v = UNITY;
      2: v = CFG_DATA_W'($urandom_range(131071, 65537));
      default: v = CFG_DATA_W'($urandom_range(65536, 1));
    endcase
    write_reg(REG_MIX, v);
    case ($urandom_range(4))
      0: v = '0;
      1: v = CFG_DATA_W'(16'hFFFF);
      default: v = CFG_DATA_W'($urandom_range(131071));
    endcase
    write_reg(REG_ALPHA, v);
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(255, 4)), CFG_DATA_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random backpressure, or a long hold-off when requested
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted result against the oldest owed pair
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stereo_t want;
    sample_t got_l;
    sample_t got_r;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got_l = out_tdata[SMP_W-1:0];
      got_r = out_tdata[2*SMP_W-1:SMP_W];
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result transaction left %0d right %0d",
                 $realtime, got_l, got_r);
        mismatch_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (got_l !== want.left) begin
          $display("%0t: left_out mismatch expected %0d actual %0d",
                   $realtime, want.left, got_l);
          mismatch_count++;
        end
        if (got_r !== want.right) begin
          $display("%0t: right_out mismatch expected %0d actual %0d",
                   $realtime, want.right, got_r);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset mix is zero, so pairs must pass straight through
  task automatic test_bypass_passthrough();
    send_pair(SMP_MAX, SMP_MIN);
    send_pair(SMP_MIN, SMP_MAX);
    send_pair('0, '1);
    send_pair(sample_t'(12345), sample_t'(-54321));
    wait_results_drained();
  endtask

  // only mix changed, reset distance of 24000 reads silence from the line
  task automatic test_reset_settings();
    write_reg(REG_MIX, UNITY);
    send_pair(SMP_MAX, SMP_MIN);
    send_pair(sample_t'(-777), sample_t'(4242));
    wait_results_drained();
  endtask

  // clamped distance, gains above unity, masked alpha, ignored indexes, freeze
  task automatic test_echo_corners();
    write_reg(REG_DELAY, '0);
    write_reg(REG_FEEDBACK, '1);
    write_reg(REG_MIX, '1);
    write_reg(REG_ALPHA, CFG_DATA_W'(17'h10000));
    // impulse, then rails to drive the feedback sums into saturation
    send_pair(SMP_MAX, SMP_MIN);
    repeat (3) send_pair(SMP_MAX, SMP_MAX);
    repeat (3) send_pair('0, '0);
    wait_results_drained();
    // slowest pole, half mix, writes past the register map in between
    write_reg(REG_ALPHA, CFG_DATA_W'(16'hFFFF));
    write_reg(REG_SPARE, '1);
    write_reg(REG_TOP, CFG_DATA_W'(17'h00005));
    write_reg(REG_MIX, CFG_DATA_W'(32768));
    write_reg(REG_FEEDBACK, CFG_DATA_W'(40000));
    repeat (4) send_pair(SMP_MIN, SMP_MAX);
    wait_results_drained();
    // bypass must hold pointer, lines and filters where they were
    write_reg(REG_MIX, '0);
    send_pair(sample_t'(1), sample_t'(-1));
    send_pair(SMP_MIN, SMP_MAX);
    send_pair('0, SMP_MIN);
    wait_results_drained();
    write_reg(REG_MIX, UNITY);
    repeat (3) send_pair(rand_sample(), rand_sample());
    wait_results_drained();
  endtask

  // receiver stalls for a long stretch while pairs keep coming
  task automatic test_output_stall();
    write_reg(REG_DELAY, CFG_DATA_W'(3));
    write_reg(REG_FEEDBACK, CFG_DATA_W'(50000));
    write_reg(REG_MIX, CFG_DATA_W'(30000));
    hold_requests++;
    repeat (12) send_pair(rand_sample(), rand_sample());
    wait_results_drained();
  endtask

  // bursts of random pairs, a fresh register setting per burst
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int num_pairs);
    int sent;
    int burst;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent = 0;
    while (sent < num_pairs) begin
      configure_random();
      burst = $urandom_range(120, 20);
      if (burst > num_pairs - sent) burst = num_pairs - sent;
      repeat (burst) send_pair(rand_sample(), rand_sample());
      sent += burst;
      wait_results_drained();
    end
  endtask

  initial begin
    send_idle_pct = 21;
    recv_idle_pct = 75;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bypass_passthrough();
    test_reset_settings();
    test_echo_corners();
    test_random_traffic(21, 75, 560);
    test_output_stall();
    test_random_traffic(75, 21, 560);
    test_random_traffic(0, 0, 560);

    // all pairs sent; allow time for any stray result to show up
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_pairs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ppd_pkg.sv
rtl/ping_pong_delay_lowpass_feedback.sv
tb/ping_pong_delay_lowpass_feedback_tb.sv
